@@ hdl/subtractive_random_generator_assert.svh @@
// Assertion macros for the subtractive random generator.
`ifndef SUBTRACTIVE_RANDOM_GENERATOR_ASSERT_SVH
`define SUBTRACTIVE_RANDOM_GENERATOR_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SRG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srg: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SRG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srg: next-cycle check failed");

`endif

@@ hdl/srg_pkg.sv @@
// Package with constants and sequencer states of the subtractive random generator.
package srg_pkg;

	localparam int unsigned ValW  = 30;
	localparam int unsigned IdxW  = 6;
	localparam int unsigned SeedW = 28;

	localparam logic [ValW-1:0]  Modulus    = 30'd1000000000;
	localparam logic [SeedW-1:0] SeedConst  = 28'd161803398;
	localparam logic [IdxW-1:0]  Stride     = 6'd21;
	localparam logic [IdxW-1:0]  TableLen   = 6'd55;
	localparam logic [IdxW-1:0]  TrailStart = 6'd31;
	localparam logic [IdxW-1:0]  MixLag     = 6'd30;
	localparam logic [IdxW-1:0]  FillSteps  = 6'd54;
	localparam logic [1:0]       LastPass   = 2'd3;

	localparam logic CmdNext   = 1'b0;
	localparam logic CmdReseed = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEED,
		S_FILL,
		S_MIX_RD,
		S_MIX_WR,
		S_GEN_RD,
		S_GEN_WR
	} srg_state_t;

	// Advance a ring index, wrapping past the last entry back to one.
	function automatic logic [IdxW-1:0] srg_next_idx(input logic [IdxW-1:0] idx);
		logic [IdxW:0] inc;
		inc = {1'b0, idx} + 7'd1;
		if (inc >= 7'd56) begin
			srg_next_idx = 6'd1;
		end else begin
			srg_next_idx = inc[IdxW-1:0];
		end
	endfunction

endpackage

@@ hdl/subtractive_random_generator.sv @@
// Subtractive lagged random generator with a 55-entry table and a shared subtract unit.
//
// Usage: each request on the slave stream yields exactly one value on the master
// stream. s_axis_tuser[0] is the command: 0 asks for the next value, 1 rebuilds the
// table from the seed magnitude in s_axis_tdata[27:0] and then gives a value. The
// first request after reset always rebuilds the table, whatever its command.
// Seeds above 161803398 saturate at that value.
// Sequence: a plain request passes through a table read state and then a
// subtract-and-write state before its value shows on m_axis_tvalid. A rebuild
// first runs a seed step, the fill steps and 4 x 55 mix steps, each mix step a
// read, then a subtract and write back through the one table write port.
// Intake: s_axis_tready is high only while the sequencer is idle, so the block
// takes no new request until the last one has been written to the output
// register.
// Stall: a finished value waits in the output register while the next request is
// accepted and worked on; if the receiver still holds off, the sequencer holds in
// its write cycle until the output register frees up.
// Reset: arst_n clears the sequencer, output valid, the seeded flag and the ring
// indices (lead 0, trail 31); the table itself holds garbage until the first rebuild.
`include "subtractive_random_generator_assert.svh"

module subtractive_random_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [27:0] seed_magnitude, [31:28] zero
	input  logic [0:0]  s_axis_tuser,  // [0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // [29:0] random_value, [31:30] zero
);
	import srg_pkg::*;

	srg_state_t state_q, state_nxt;

	logic             seeded_q;
	logic [IdxW-1:0]  lead_q, trail_q;
	logic [SeedW-1:0] mag_q;

	// Fill and mix bookkeeping
	logic [ValW-1:0]  cur_q, prev_q;
	logic [IdxW-1:0]  fill_pos_q;
	logic [IdxW-1:0]  step_q;
	logic [1:0]       pass_q;

	// Output register
	logic             out_valid_q;
	logic [ValW-1:0]  out_data_q;

	// Table memory, entry 0 unused
	logic [ValW-1:0]  lag_mem [0:55];
	logic [ValW-1:0]  rd_a_q, rd_b_q;
	logic [IdxW-1:0]  rd_addr_a, rd_addr_b;
	logic             mem_we;
	logic [IdxW-1:0]  mem_waddr;
	logic [ValW-1:0]  mem_wdata;

	// Shared subtract-with-wrap unit
	logic [ValW-1:0]  sub_a, sub_b, sub_y;
	logic [ValW:0]    sub_diff, sub_wrap;

	logic             in_fire, out_fire, out_free;
	logic [SeedW-1:0] mag_sat;
	logic [IdxW-1:0]  mix_pos;
	logic [IdxW:0]    mix_sum, fill_sum;
	logic [IdxW-1:0]  lead_nxt, trail_nxt;
	logic             fill_done, mix_last;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_data_q};

	// Subtract, and add the modulus back when it borrows
	assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_wrap = sub_diff + {1'b0, Modulus};
	assign sub_y    = sub_diff[ValW] ? sub_wrap[ValW-1:0] : sub_diff[ValW-1:0];

	// Clamp the seed so the starting value never goes negative
	assign mag_sat = (mag_q > SeedConst) ? SeedConst : mag_q;

	// Mix partner: 1 + (i + 30) mod 55
	assign mix_sum = {1'b0, step_q} + {1'b0, MixLag} + 7'd1;
	assign mix_pos = (mix_sum > {1'b0, TableLen}) ? 6'(mix_sum - {1'b0, TableLen})
	                                              : mix_sum[IdxW-1:0];

	// Fill position: advance by the stride mod 55
	assign fill_sum = {1'b0, fill_pos_q} + {1'b0, Stride};

	assign lead_nxt  = srg_next_idx(lead_q);
	assign trail_nxt = srg_next_idx(trail_q);

	assign fill_done = (step_q == FillSteps);
	assign mix_last  = (step_q == TableLen) && (pass_q == LastPass);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (s_axis_tuser[0] == CmdReseed || !seeded_q) begin
						state_nxt = S_SEED;
					end else begin
						state_nxt = S_GEN_RD;
					end
				end
			end
			S_SEED:   state_nxt = S_FILL;
			S_FILL:   state_nxt = fill_done ? S_MIX_RD : S_FILL;
			S_MIX_RD: state_nxt = S_MIX_WR;
			S_MIX_WR: state_nxt = mix_last ? S_GEN_RD : S_MIX_RD;
			S_GEN_RD: state_nxt = S_GEN_WR;
			S_GEN_WR: state_nxt = out_free ? S_IDLE : S_GEN_WR;
			default:  state_nxt = S_IDLE;
		endcase
	end

	// Table port and subtract unit steering
	always_comb begin
		rd_addr_a = step_q;
		rd_addr_b = mix_pos;
		mem_we    = 1'b0;
		mem_waddr = fill_pos_q;
		mem_wdata = prev_q;
		sub_a     = rd_a_q;
		sub_b     = rd_b_q;
		unique case (state_q)
			S_SEED: begin
				sub_a     = {2'b00, SeedConst};
				sub_b     = {2'b00, mag_sat};
				mem_we    = 1'b1;
				mem_waddr = TableLen;
				mem_wdata = sub_y;
			end
			S_FILL: begin
				sub_a  = cur_q;
				sub_b  = prev_q;
				mem_we = 1'b1;
			end
			S_MIX_WR: begin
				mem_we    = 1'b1;
				mem_waddr = step_q;
				mem_wdata = sub_y;
			end
			S_GEN_RD: begin
				rd_addr_a = lead_nxt;
				rd_addr_b = trail_nxt;
			end
			S_GEN_WR: begin
				// Keep reading the same pair so a stalled write still sees its operands
				rd_addr_a = lead_q;
				rd_addr_b = trail_q;
				mem_we    = out_free;
				mem_waddr = lead_q;
				mem_wdata = sub_y;
			end
			S_IDLE, S_MIX_RD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			lag_mem[mem_waddr] <= mem_wdata;
		end
		rd_a_q <= lag_mem[rd_addr_a];
		rd_b_q <= lag_mem[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seeded_q    <= 1'b0;
			lead_q      <= '0;
			trail_q     <= TrailStart;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_MIX_WR && mix_last) begin
				// Restart the ring indices after a rebuild
				seeded_q <= 1'b1;
				lead_q   <= '0;
				trail_q  <= TrailStart;
			end
			if (state_q == S_GEN_RD) begin
				lead_q  <= lead_nxt;
				trail_q <= trail_nxt;
			end
			if (state_q == S_GEN_WR && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mag_q <= s_axis_tdata[SeedW-1:0];
		end
		unique case (state_q)
			S_SEED: begin
				cur_q      <= sub_y;
				prev_q     <= 30'd1;
				fill_pos_q <= Stride;
				step_q     <= 6'd1;
			end
			S_FILL: begin
				prev_q     <= sub_y;
				cur_q      <= prev_q;
				fill_pos_q <= (fill_sum >= {1'b0, TableLen}) ? 6'(fill_sum - {1'b0, TableLen})
				                                             : fill_sum[IdxW-1:0];
				if (fill_done) begin
					step_q <= 6'd1;
					pass_q <= 2'd0;
				end else begin
					step_q <= step_q + 6'd1;
				end
			end
			S_MIX_WR: begin
				if (step_q == TableLen) begin
					step_q <= 6'd1;
					pass_q <= pass_q + 2'd1;
				end else begin
					step_q <= step_q + 6'd1;
				end
			end
			S_GEN_WR: begin
				if (out_free) begin
					out_data_q <= sub_y;
				end
			end
			S_IDLE, S_MIX_RD, S_GEN_RD: begin
			end
			default: begin
			end
		endcase
	end

	// A reseed request always starts a rebuild
	`SRG_ASSERT_NEXT(a_reseed_rebuilds, in_fire && (s_axis_tuser[0] == CmdReseed), state_q == S_SEED)
	// Values are only generated from a seeded table
	`SRG_ASSERT_NOW(a_gen_seeded, state_q == S_GEN_RD || state_q == S_GEN_WR, seeded_q)
	// Writes never touch the unused entry or go past the table
	`SRG_ASSERT_NOW(a_write_range, mem_we, mem_waddr != 6'd0 && mem_waddr <= TableLen)
	// Every delivered value lies below the modulus
	`SRG_ASSERT_NOW(a_value_range, out_valid_q, out_data_q < Modulus)

endmodule

@@ tb/srg_checker.sv @@
// Checker for the subtractive random generator: predicts each value and compares it.
module srg_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	input  logic [31:0]       s_axis_tdata,  // [27:0] seed_magnitude, [31:28] zero
	input  logic [0:0]        s_axis_tuser,  // [0] cmd
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic [31:0]       m_axis_tdata,  // [29:0] random_value, [31:30] zero
	output int unsigned       pending,
	output int unsigned       mismatches
);
	timeunit 1ns;
	timeprecision 1ps;
	import srg_pkg::*;

	logic [ValW-1:0] lag_copy [1:55];
	logic [IdxW-1:0] lead_pos;
	logic [IdxW-1:0] trail_pos;
	logic            table_seeded;
	logic [ValW-1:0] expected_values [$];
	int unsigned     mismatch_total;

	assign mismatches = mismatch_total;

	function automatic logic [ValW-1:0] wrap_difference(input logic [ValW-1:0] a,
			input logic [ValW-1:0] b);
		logic [ValW:0] diff;
		if (a < b) begin
			diff = {1'b0, a} + {1'b0, Modulus} - {1'b0, b};
		end else begin
			diff = {1'b0, a} - {1'b0, b};
		end
		return diff[ValW-1:0];
	endfunction

	function automatic void rebuild_lag_table(input logic [SeedW-1:0] magnitude);
		logic [SeedW-1:0] mag;
		logic [ValW-1:0]  cur;
		logic [ValW-1:0]  prev;
		int               slot;
		mag = (magnitude > SeedConst) ? SeedConst : magnitude;
		cur = ValW'(SeedConst - mag);
		lag_copy[TableLen] = cur;
		prev = ValW'(1);
		for (int i = 1; i <= int'(FillSteps); i++) begin
			slot = (int'(Stride) * i) % int'(TableLen);
			lag_copy[slot] = prev;
			prev = wrap_difference(cur, prev);
			cur = lag_copy[slot];
		end
		for (int pass = 0; pass <= int'(LastPass); pass++) begin
			for (int i = 1; i <= int'(TableLen); i++) begin
				slot = 1 + (i + int'(MixLag)) % int'(TableLen);
				lag_copy[i] = wrap_difference(lag_copy[i], lag_copy[slot]);
			end
		end
		lead_pos = '0;
		trail_pos = TrailStart;
		table_seeded = 1'b1;
	endfunction

	function automatic logic [ValW-1:0] next_random_value(input logic cmd,
			input logic [SeedW-1:0] magnitude);
		logic [ValW-1:0] value;
		if (cmd == CmdReseed || !table_seeded) begin
			rebuild_lag_table(magnitude);
		end
		lead_pos = (lead_pos >= TableLen) ? IdxW'(1) : lead_pos + 1'b1;
		trail_pos = (trail_pos >= TableLen) ? IdxW'(1) : trail_pos + 1'b1;
		value = wrap_difference(lag_copy[lead_pos], lag_copy[trail_pos]);
		lag_copy[lead_pos] = value;
		return value;
	endfunction

	task automatic report_mismatch(input string what, input logic [ValW-1:0] want,
			input logic [ValW-1:0] got);
		$display("%0t srg: %s: expected %0d, got %0d", $realtime, what, want, got);
		mismatch_total++;
	endtask

	initial mismatch_total = 0;

	// Compare before predicting: no value can leave in the cycle its request enters.
	always @(posedge clk or negedge arst_n) begin
		logic [ValW-1:0] want;
		if (!arst_n) begin
			lead_pos = '0;
			trail_pos = TrailStart;
			table_seeded = 1'b0;
			expected_values.delete();
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_values.size() == 0) begin
					report_mismatch("value with no request waiting", '0, m_axis_tdata[ValW-1:0]);
				end else begin
					want = expected_values.pop_front();
					if (m_axis_tdata[ValW-1:0] !== want) begin
						report_mismatch("random_value", want, m_axis_tdata[ValW-1:0]);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_values.push_back(next_random_value(s_axis_tuser[0],
					s_axis_tdata[SeedW-1:0]));
			end
			pending <= expected_values.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
// Top of the subtractive random generator testbench: clock, reset, requests and verdict.
module testbench;
	import srg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Random requests after the directed ones, and how many at the end run without idling.
	localparam int unsigned RandomItems = 1530;
	localparam int unsigned CalmItems   = 150;
	// A rebuild keeps both streams quiet while it runs; the limit must outlast that.
	localparam int unsigned StallLimit  = 4000;
	localparam int unsigned DrainCycles = 12;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;  // [27:0] seed_magnitude, [31:28] zero
	logic [0:0]  s_axis_tuser;  // [0] cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;  // [29:0] random_value, [31:30] zero

	int unsigned pending;
	int unsigned mismatches;
	logic        calm;

	subtractive_random_generator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	srg_checker value_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.pending       (pending),
		.mismatches    (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Drive one request from a falling edge and hold it until the block takes it.
	// Sometimes drop valid for a short burst first, unless the run is in its calm tail.
	task automatic send_request(input logic cmd, input logic [SeedW-1:0] magnitude);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {4'b0, magnitude};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Receiver: alternate ready stretches with stall bursts; stay ready once calm.
	initial begin : receiver
		int unsigned span;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm || $urandom_range(0, 2) != 0) begin
				m_axis_tready <= 1'b1;
				span = $urandom_range(1, 30);
			end else begin
				m_axis_tready <= 1'b0;
				span = $urandom_range(1, 10);
			end
			repeat (span - 1) @(negedge clk);
		end
	end

	// End the run when neither stream moves for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < StallLimit) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("testbench failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned      sent;
		int unsigned      run_len;
		logic [SeedW-1:0] seed;

		arst_n = 1'b0;
		calm = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = CmdNext;
		s_axis_tdata = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// First request after reset is a plain one: the table must still be built from its seed.
		send_request(CmdNext, '0);
		// Plain requests ignore the seed field; toggle its bits anyway.
		send_request(CmdNext, 28'hFFFFFFF);
		send_request(CmdNext, 28'h5555555);
		send_request(CmdNext, 28'hAAAAAAA);
		// Seed equal to the seed constant: starting value zero.
		send_request(CmdReseed, SeedConst);
		send_request(CmdNext, '0);
		// Seeds above the constant saturate, up to the widest field value.
		send_request(CmdReseed, SeedConst + 1'b1);
		send_request(CmdReseed, 28'hFFFFFFF);
		send_request(CmdNext, 28'hFFFFFFF);
		send_request(CmdReseed, '0);
		send_request(CmdReseed, 28'd1);
		send_request(CmdNext, '0);
		send_request(CmdReseed, 28'h5555555);
		send_request(CmdReseed, 28'hAAAAAAA);
		send_request(CmdNext, 28'h5555555);
		send_request(CmdReseed, SeedConst - 1'b1);
		send_request(CmdNext, '0);

		// Random part: a rebuild followed by a run of plain requests. Long runs carry the
		// ring indices past their wrap; short ones give back-to-back rebuilds.
		sent = 0;
		while (sent < RandomItems) begin
			case ($urandom_range(0, 5))
				0: seed = SeedW'($urandom);
				1: seed = SeedConst - SeedW'($urandom_range(0, 3));
				2: seed = SeedConst + SeedW'($urandom_range(0, 3));
				3: seed = SeedW'($urandom_range(0, 3));
				default: seed = SeedW'($urandom_range(0, SeedConst));
			endcase
			send_request(CmdReseed, seed);
			sent++;
			run_len = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) : $urandom_range(20, 140);
			for (int unsigned n = 0; n < run_len && sent < RandomItems; n++) begin
				send_request(CmdNext, SeedW'($urandom));
				sent++;
				calm <= (sent + CalmItems >= RandomItems);
			end
			calm <= (sent + CalmItems >= RandomItems);
		end
		s_axis_tvalid <= 1'b0;

		// Wait out every value still owed, then wait DrainCycles longer for strays.
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
